@@ rtl/core/ldt_pkg.sv @@
// ldt_pkg: shared types and constants for the layout dedup table
// field widths, function codes, entry layout, controller/datapath interface structs
// no dependencies
package ldt_pkg;

    localparam int PERIOD_W      = 16;
    localparam int ROWS_W        = 12;
    localparam int START_W       = 40;
    localparam int NUMBER_W      = 6;
    localparam int DEFAULT_MAX_ENTRIES = 32;

    // function codes carried by func
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [ROWS_W-1:0]   num_rows;
        logic [START_W-1:0]  start_time;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // take a new word from the input port
        logic scan_step;  // issue the next table read and advance
        logic finish;     // resolve the item and load the output register
    } ldt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;   // held item is a clear request
        logic hit;        // compared entry matches the held item
        logic scan_end;   // every stored entry compared, none matched
        logic out_free;   // output register can take a new word
    } ldt_stat_t;

endpackage

@@ rtl/core/ldt_ctrl.sv @@
// ldt_ctrl: sequencer for the layout dedup table
// walks idle -> scan -> finish and drives datapath commands
// depends on ldt_pkg
module ldt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldt_pkg::ldt_stat_t stat,
    output ldt_pkg::ldt_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // clear words skip the scan entirely
                if (stat.is_clear || stat.hit || stat.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/ldt_dpath.sv @@
// ldt_dpath: entry memory, entry count, scan pointer, comparator and output register
// acts only on commands from ldt_ctrl
// depends on ldt_pkg
module ldt_dpath
#(
    parameter int MAX_ENTRIES = ldt_pkg::DEFAULT_MAX_ENTRIES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ldt_pkg::ldt_cmd_t              cmd,
    output ldt_pkg::ldt_stat_t             stat,
    input  logic                           func,
    input  logic [ldt_pkg::PERIOD_W-1:0]   period,
    input  logic [ldt_pkg::ROWS_W-1:0]     num_rows,
    input  logic [ldt_pkg::START_W-1:0]    start_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_new,
    output logic [ldt_pkg::NUMBER_W-1:0]   layout_number,
    output logic                           table_full
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = (CW > ldt_pkg::NUMBER_W) ? CW : ldt_pkg::NUMBER_W;

    ldt_pkg::entry_t mem [MAX_ENTRIES];

    ldt_pkg::entry_t item_reg;
    logic            clear_reg;
    ldt_pkg::entry_t rd_data_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   addr_reg;
    logic [IW-1:0]   cmp_idx_reg;
    logic            cmp_vld_reg;

    logic                          out_valid_reg;
    logic                          is_new_reg;
    logic [ldt_pkg::NUMBER_W-1:0]  number_reg;
    logic                          full_reg;

    logic          read_en;
    logic          write_en;
    logic          at_cap;
    logic [CW-1:0] hit_num;
    logic [CW-1:0] new_num;
    logic [WW-1:0] hit_num_w;
    logic [WW-1:0] new_num_w;

    assign stat.is_clear = clear_reg;
    assign stat.hit      = cmp_vld_reg && (rd_data_reg == item_reg);
    assign stat.scan_end = (addr_reg == count_reg) && !stat.hit;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign read_en  = cmd.scan_step && (addr_reg < count_reg);
    assign at_cap   = (count_reg == CW'(MAX_ENTRIES));
    assign write_en = cmd.finish && !clear_reg && !stat.hit && !at_cap;

    assign hit_num   = CW'(cmp_idx_reg) + CW'(1);
    assign new_num   = count_reg + CW'(1);
    assign hit_num_w = WW'(hit_num);
    assign new_num_w = WW'(new_num);

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[count_reg[IW-1:0]] <= item_reg;
        end
        if (read_en)
        begin
            rd_data_reg <= mem[addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg.period     <= period;
            item_reg.num_rows   <= num_rows;
            item_reg.start_time <= start_time;
            clear_reg           <= (func == ldt_pkg::FUNC_CLEAR);
        end
        if (read_en)
        begin
            cmp_idx_reg <= addr_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            addr_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg    <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                cmp_vld_reg <= read_en;
                if (read_en)
                begin
                    addr_reg <= addr_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                if (clear_reg)
                begin
                    count_reg <= '0;
                end
                else if (write_en)
                begin
                    count_reg <= new_num;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (clear_reg)
            begin
                is_new_reg <= 1'b0;
                number_reg <= '0;
                full_reg   <= 1'b0;
            end
            else if (stat.hit)
            begin
                is_new_reg <= 1'b0;
                number_reg <= hit_num_w[ldt_pkg::NUMBER_W-1:0];
                full_reg   <= 1'b0;
            end
            else if (at_cap)
            begin
                is_new_reg <= 1'b0;
                number_reg <= '0;
                full_reg   <= 1'b1;
            end
            else
            begin
                is_new_reg <= 1'b1;
                number_reg <= new_num_w[ldt_pkg::NUMBER_W-1:0];
                full_reg   <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_new        = is_new_reg;
    assign layout_number = number_reg;
    assign table_full    = full_reg;

endmodule

@@ rtl/core/layout_dedup_table_unit.sv @@
// layout_dedup_table_unit: top level of the layout dedup table
// joins the sequencer (ldt_ctrl) and the datapath (ldt_dpath)
// depends on ldt_pkg, ldt_ctrl, ldt_dpath
//
// Deduplicating lookup-or-insert table of time layouts. Each input word is
// either a lookup (func = 0) carrying period, num_rows and start_time, or a
// clear (func = 1). A lookup reads the stored entries one per cycle, oldest
// first, from an entry memory with one write and one read port; the first
// full match returns its 1-based number with is_new low, otherwise the
// layout is appended and its new number returned with is_new high. With the
// table full an unmatched layout is dropped and table_full is raised with
// layout_number zero. layout_number is the entry number modulo 64. One word
// is processed at a time: a lookup scans until a hit or until every stored
// entry is read, and a clear skips the scan. The result is registered once
// the output register is free; in_ready rises again as it is registered,
// so a new word is taken while the previous result waits on out_ready. No
// clearing pass is needed after reset: only entries below the live count
// are ever read.
module layout_dedup_table_unit
#(
    parameter int MAX_ENTRIES = ldt_pkg::DEFAULT_MAX_ENTRIES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [ldt_pkg::PERIOD_W-1:0]   period,
    input  logic [ldt_pkg::ROWS_W-1:0]     num_rows,
    input  logic [ldt_pkg::START_W-1:0]    start_time,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_new,
    output logic [ldt_pkg::NUMBER_W-1:0]   layout_number,
    output logic                           table_full
);

    ldt_pkg::ldt_cmd_t  cmd;
    ldt_pkg::ldt_stat_t stat;

    // sequencer: idle, scan, finish
    ldt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry memory, count, comparator and output register
    ldt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .period        (period),
        .num_rows      (num_rows),
        .start_time    (start_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_new        (is_new),
        .layout_number (layout_number),
        .table_full    (table_full)
    );

endmodule

@@ rtl/core/ldt_checker.sv @@
// ldt_checker: port-level assertions for layout_dedup_table_unit
// attached by the bind at the end of this file
// depends on ldt_pkg
module ldt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          is_new,
    input logic [ldt_pkg::NUMBER_W-1:0]  layout_number,
    input logic                          table_full
);

    // one word at a time: an accepted word blocks the input for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again directly after a word was accepted");

    // a stored layout is never also reported as dropped
    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && table_full))
        else $error("is_new and table_full both set");

    // a dropped layout carries no entry number
    a_full_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> (layout_number == '0))
        else $error("table_full with non-zero layout_number");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(is_new) && $stable(layout_number) && $stable(table_full)))
        else $error("result word changed while stalled");

endmodule

bind layout_dedup_table_unit ldt_checker u_ldt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_new        (is_new),
    .layout_number (layout_number),
    .table_full    (table_full)
);
